// ----- hdl/lbg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_pkg: shared definitions of the LED bar graph frame buffer
// Field widths, request codes and the geometry of the 10 x 20 bar display.
// ----------------------------------------------------------------------------
package lbg_pkg;

    localparam int FRAME_WORDS_DEF = 16;

    localparam int REQ_TYPE_W   = 3;
    localparam int BAR_W        = 4;
    localparam int LEVEL_W      = 8;
    localparam int WORD_INDEX_W = 4;
    localparam int WORD_W       = 16;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_BAR_HEIGHT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_BAR_RANGE  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_DOT        = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_BAR  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_PIXEL      = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_ALL  = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_READOUT    = 3'd6;

    // display geometry
    localparam int BAR_ROWS  = 20;
    localparam int LO_ROWS   = 16;               // rows held in the bar's own word
    localparam int HI_ROWS   = BAR_ROWS - LO_ROWS;
    localparam logic [BAR_W-1:0] LAST_BAR   = 4'd9;
    localparam logic [BAR_W-1:0] SPLIT_BAR  = 4'd6;   // bars from here use the right block
    localparam logic [BAR_W-1:0] HI_BASE_L  = 4'd10;  // 8+2
    localparam logic [BAR_W-1:0] HI_BASE_R  = 4'd4;
    localparam logic [LEVEL_W-1:0] HEIGHT_NEG = 8'd127;
    localparam logic [LEVEL_W-1:0] HEIGHT_MAX = 8'd20;
    localparam logic [LEVEL_W-1:0] ROW_MAX    = 8'd19;

endpackage
`default_nettype wire

// ----- hdl/lbg_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_req_if: request channel
// Valid/ready channel carrying one draw or readout request per beat.
// ----------------------------------------------------------------------------
interface lbg_req_if;
    logic                             valid;
    logic                             ready;
    logic [lbg_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [lbg_pkg::BAR_W-1:0]        bar;
    logic [lbg_pkg::LEVEL_W-1:0]      height;
    logic [lbg_pkg::LEVEL_W-1:0]      bottom;
    logic [lbg_pkg::LEVEL_W-1:0]      top;
    logic [lbg_pkg::LEVEL_W-1:0]      row;
    logic                             pixel_on;

    modport source (output valid, req_type, bar, height, bottom, top, row, pixel_on,
                    input ready);
    modport sink   (input valid, req_type, bar, height, bottom, top, row, pixel_on,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/lbg_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_rsp_if: readout channel
// Valid/ready channel carrying one frame word per beat.
// ----------------------------------------------------------------------------
interface lbg_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [lbg_pkg::WORD_INDEX_W-1:0]   word_index;
    logic [lbg_pkg::WORD_W-1:0]         frame_word;
    logic                               last;

    modport source (output valid, word_index, frame_word, last, input ready);
    modport sink   (input valid, word_index, frame_word, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/led_bar_graph_frame_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_bar_graph_frame_buffer: frame store for a 10-bar by 20-LED graph
// Applies draw requests to a 16 x 16-bit frame and streams it out on demand.
// ----------------------------------------------------------------------------
// Usage
//   req : one request per beat (bar height, bar range, dot, clear bar, pixel,
//         clear all, readout). Draw requests produce no beat on rsp.
//   rsp : a readout yields sixteen beats, words 0..15, last high on word 15.
// Sequence
//   A bar, dot or pixel request: the accept cycle reads the bar's own word,
//   state S_LO writes it back and reads the word holding the top four rows,
//   and state S_HI writes that back. The single read port of the frame memory
//   forces this split. Ignored requests leave the block idle.
//   Clear all: the accept cycle, then one word written per cycle.
//   Readout: after the accept cycle each word is read in S_RO_RD, then loaded
//   into the output register in S_RO_LD once the register is free.
// Reset
//   After rst_n is released a clearing pass zeroes the frame;
//   req.ready stays low until it ends.
// Stalls
//   A stalled rsp holds the output register and pauses the readout. Requests
//   are taken again once the last word is loaded, even while it waits.
// ----------------------------------------------------------------------------
module led_bar_graph_frame_buffer #(
    parameter int FRAME_WORDS = lbg_pkg::FRAME_WORDS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbg_req_if.sink    req,
    lbg_rsp_if.source  rsp
);

    localparam int AW = $clog2(FRAME_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_WORDS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LO    = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_RO_RD = 3'd4;
    localparam logic [2:0] S_RO_LD = 3'd5;

    // frame memory
    logic [lbg_pkg::WORD_W-1:0] mem [FRAME_WORDS];
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [lbg_pkg::WORD_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [lbg_pkg::WORD_W-1:0]  rd_data_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;
    logic          load_out;

    // decoded draw request, held for the read-modify-write
    logic [lbg_pkg::BAR_W-1:0]    bar_reg;
    logic [lbg_pkg::BAR_ROWS-1:0] chg_reg, val_reg;   // indexed by row from bottom
    logic [lbg_pkg::BAR_ROWS-1:0] chg_c, val_c;
    logic                         draw_c;

    logic [AW-1:0]               out_idx_reg;
    logic [lbg_pkg::WORD_W-1:0]  out_word_reg;
    logic                        out_last_reg;

    logic [lbg_pkg::BAR_W-1:0]   hi_addr;
    logic [lbg_pkg::WORD_W-1:0]  hi_chg, hi_val;

    // clamped levels, row numbers from the bottom
    logic [4:0] h_c, t_c, bo_c, dot_c, pix_c;

    always_comb
    begin
        if (req.height > lbg_pkg::HEIGHT_NEG)
            h_c = 5'd0;
        else if (req.height > lbg_pkg::HEIGHT_MAX)
            h_c = lbg_pkg::HEIGHT_MAX[4:0];
        else
            h_c = req.height[4:0];

        t_c = (req.top > lbg_pkg::ROW_MAX) ? lbg_pkg::ROW_MAX[4:0] : req.top[4:0];
        bo_c = (req.bottom > lbg_pkg::ROW_MAX) ? lbg_pkg::ROW_MAX[4:0] : req.bottom[4:0];
        if (bo_c > t_c)
            bo_c = t_c;
        dot_c = (req.row > lbg_pkg::ROW_MAX) ? lbg_pkg::ROW_MAX[4:0] : req.row[4:0];
        // pixel line counts from the top: flip to a row from the bottom
        pix_c = lbg_pkg::ROW_MAX[4:0] - req.row[4:0];

        chg_c  = '0;
        val_c  = '0;
        draw_c = 1'b0;
        case (req.req_type)
            lbg_pkg::REQ_BAR_HEIGHT:
            begin
                chg_c  = '1;
                draw_c = 1'b1;
                for (int u = 0; u < lbg_pkg::BAR_ROWS; u++)
                    val_c[u] = (5'(u) < h_c);
            end
            lbg_pkg::REQ_BAR_RANGE:
            begin
                chg_c  = '1;
                draw_c = 1'b1;
                for (int u = 0; u < lbg_pkg::BAR_ROWS; u++)
                    val_c[u] = (5'(u) <= t_c) && (5'(u) >= bo_c);
            end
            lbg_pkg::REQ_DOT:
            begin
                chg_c  = lbg_pkg::BAR_ROWS'(1) << dot_c;
                val_c  = chg_c;
                draw_c = 1'b1;
            end
            lbg_pkg::REQ_CLEAR_BAR:
            begin
                chg_c  = '1;
                draw_c = 1'b1;
            end
            lbg_pkg::REQ_PIXEL:
            begin
                chg_c  = lbg_pkg::BAR_ROWS'(1) << pix_c;
                val_c  = req.pixel_on ? chg_c : '0;
                draw_c = (req.row <= lbg_pkg::ROW_MAX);
            end
            default:
            begin
                draw_c = 1'b0;
            end
        endcase
        // drop draws aimed past the last bar
        if (req.bar > lbg_pkg::LAST_BAR)
            draw_c = 1'b0;
    end

    // word holding the top four rows of the held bar, and its bit lane
    always_comb
    begin
        if (bar_reg < lbg_pkg::SPLIT_BAR)
        begin
            hi_addr = bar_reg + lbg_pkg::HI_BASE_L;
            hi_chg  = lbg_pkg::WORD_W'(chg_reg[lbg_pkg::BAR_ROWS-1:lbg_pkg::LO_ROWS]);
            hi_val  = lbg_pkg::WORD_W'(val_reg[lbg_pkg::BAR_ROWS-1:lbg_pkg::LO_ROWS]);
        end
        else
        begin
            hi_addr = bar_reg + lbg_pkg::HI_BASE_R;
            hi_chg  = lbg_pkg::WORD_W'(chg_reg[lbg_pkg::BAR_ROWS-1:lbg_pkg::LO_ROWS])
                      << lbg_pkg::HI_ROWS;
            hi_val  = lbg_pkg::WORD_W'(val_reg[lbg_pkg::BAR_ROWS-1:lbg_pkg::LO_ROWS])
                      << lbg_pkg::HI_ROWS;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == S_RO_LD) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(req.bar);
                    cnt_next = '0;
                    if (req.req_type == lbg_pkg::REQ_CLEAR_ALL)
                        state_next = S_CLEAR;
                    else if (req.req_type == lbg_pkg::REQ_READOUT)
                        state_next = S_RO_RD;
                    else if (draw_c)
                        state_next = S_LO;
                end
            end
            S_LO:
            begin
                // write back the bar's own word, fetch its top-rows word
                wr_en      = 1'b1;
                wr_addr    = AW'(bar_reg);
                wr_data    = (rd_data_reg & ~chg_reg[lbg_pkg::LO_ROWS-1:0])
                           | (val_reg[lbg_pkg::LO_ROWS-1:0] & chg_reg[lbg_pkg::LO_ROWS-1:0]);
                rd_en      = 1'b1;
                rd_addr    = AW'(hi_addr);
                state_next = S_HI;
            end
            S_HI:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(hi_addr);
                wr_data    = (rd_data_reg & ~hi_chg) | (hi_val & hi_chg);
                state_next = S_IDLE;
            end
            S_RO_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_RO_LD;
            end
            S_RO_LD:
            begin
                // hold the fetched word until the output register frees up
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = (cnt_reg == LAST_ADDR) ? S_IDLE : S_RO_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bar_reg <= req.bar;
            chg_reg <= chg_c;
            val_reg <= val_c;
        end
        if (load_out)
        begin
            out_idx_reg  <= cnt_reg;
            out_word_reg <= rd_data_reg;
            out_last_reg <= (cnt_reg == LAST_ADDR);
        end
    end

    // frame memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.word_index = lbg_pkg::WORD_INDEX_W'(out_idx_reg);
    assign rsp.frame_word = out_word_reg;
    assign rsp.last       = out_last_reg;

endmodule
`default_nettype wire

// ----- tb/sv/lbg_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbg_frame_checker: scoreboard for the LED bar graph frame buffer
// Watches both channels, keeps a shadow frame updated on every request beat
// and compares each readout beat with the oldest predicted word.
// ----------------------------------------------------------------------------
module lbg_frame_checker
    import lbg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lbg_req_if        req,
    lbg_rsp_if        rsp,
    output int        mismatch_count,
    output int        pending_words
);

    typedef struct {
        logic [WORD_INDEX_W-1:0] idx;
        logic [WORD_W-1:0]       word;
        logic                    last;
    } frame_beat_t;

    logic [WORD_W-1:0] frame_shadow [FRAME_WORDS_DEF];
    frame_beat_t       readout_words [$];

    // light or clear one LED; r counts rows from the top
    function automatic void set_led(input logic [BAR_W-1:0] b, input int r, input logic lit);
        logic [WORD_INDEX_W-1:0] w;
        logic [WORD_W-1:0]       m;
        if (r >= HI_ROWS)
        begin
            w = b;
            m = 16'd1 << (BAR_ROWS - 1 - r);
        end
        else if (b < SPLIT_BAR)
        begin
            w = HI_BASE_L + b;
            m = 16'd1 << (HI_ROWS - 1 - r);
        end
        else
        begin
            w = HI_BASE_R + b;
            m = 16'd1 << (2 * HI_ROWS - 1 - r);
        end
        if (lit)
            frame_shadow[w] = frame_shadow[w] | m;
        else
            frame_shadow[w] = frame_shadow[w] & ~m;
    endfunction

    function automatic void draw_into_frame(
        input logic [REQ_TYPE_W-1:0] kind,
        input logic [BAR_W-1:0]      b,
        input logic [LEVEL_W-1:0]    height,
        input logic [LEVEL_W-1:0]    bottom,
        input logic [LEVEL_W-1:0]    top,
        input logic [LEVEL_W-1:0]    row,
        input logic                  lit
    );
        int          lvl;
        int          lo;
        int          hi;
        frame_beat_t fb;
        if (kind == REQ_CLEAR_ALL)
        begin
            foreach (frame_shadow[i])
                frame_shadow[i] = '0;
        end
        else if (kind == REQ_READOUT)
        begin
            for (int i = 0; i < FRAME_WORDS_DEF; i++)
            begin
                fb.idx  = WORD_INDEX_W'(i);
                fb.word = frame_shadow[i];
                fb.last = (i == FRAME_WORDS_DEF - 1);
                readout_words.push_back(fb);
            end
        end
        else if (b <= LAST_BAR)
        begin
            case (kind)
                REQ_BAR_HEIGHT:
                begin
                    lvl = int'(height);
                    if (lvl > int'(HEIGHT_NEG))
                        lvl = 0;
                    if (lvl > int'(HEIGHT_MAX))
                        lvl = int'(HEIGHT_MAX);
                    for (int r = 0; r < BAR_ROWS; r++)
                        set_led(b, r, r >= BAR_ROWS - lvl);
                end
                REQ_BAR_RANGE:
                begin
                    hi = (top > ROW_MAX) ? int'(ROW_MAX) : int'(top);
                    lo = (bottom > ROW_MAX) ? int'(ROW_MAX) : int'(bottom);
                    if (lo > hi)
                        lo = hi;
                    for (int r = 0; r < BAR_ROWS; r++)
                        set_led(b, r, (r >= int'(ROW_MAX) - hi) && (r <= int'(ROW_MAX) - lo));
                end
                REQ_DOT:
                begin
                    lvl = (row > ROW_MAX) ? int'(ROW_MAX) : int'(row);
                    set_led(b, int'(ROW_MAX) - lvl, 1'b1);
                end
                REQ_CLEAR_BAR:
                begin
                    for (int r = 0; r < BAR_ROWS; r++)
                        set_led(b, r, 1'b0);
                end
                REQ_PIXEL:
                begin
                    if (row <= ROW_MAX)
                        set_led(b, int'(row), lit);
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            foreach (frame_shadow[i])
                frame_shadow[i] = '0;
            readout_words.delete();
            mismatch_count = 0;
            pending_words  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (readout_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("checker: unexpected beat idx %0d word %h last %b",
                                 rsp.word_index, rsp.frame_word, rsp.last);
                end
                else
                begin
                    want = readout_words.pop_front();
                    if (rsp.word_index !== want.idx || rsp.frame_word !== want.word ||
                        rsp.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"checker: mismatch expected idx %0d word %h last %b,",
                                      " got idx %0d word %h last %b"},
                                     want.idx, want.word, want.last,
                                     rsp.word_index, rsp.frame_word, rsp.last);
                    end
                end
            end
            if (req.valid && req.ready)
                draw_into_frame(req.req_type, req.bar, req.height, req.bottom,
                                req.top, req.row, req.pixel_on);
            pending_words = readout_words.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the frame buffer testbench
// Drives draw and readout requests with random idling on both channels and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    import lbg_pkg::*;

    // code the block must ignore; not part of the package
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 480;
    // from here on both sides run flat out
    localparam int CALM_FROM    = 420;
    // worst case is far below this: every item a readout whose sixteen
    // beats each sit out a full stall burst
    localparam int CYCLE_LIMIT  = 1000000;
    // tail after the last predicted word, well beyond one full readout
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [BAR_W-1:0]      bar;
        logic [LEVEL_W-1:0]    height;
        logic [LEVEL_W-1:0]    bottom;
        logic [LEVEL_W-1:0]    top;
        logic [LEVEL_W-1:0]    row;
        logic                  pixel_on;
    } lbg_req_t;

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          pending_words;
    int unsigned cycle_count;
    // 0: no idling, 1: light, 2: heavy; shared by both channels
    int          idle_mode;

    lbg_req_if req_ch ();
    lbg_rsp_if rsp_ch ();

    led_bar_graph_frame_buffer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lbg_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // hard stop in case the block locks up or a readout never completes
    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    function automatic lbg_req_t mk(
        input logic [REQ_TYPE_W-1:0] kind,
        input logic [BAR_W-1:0]      b,
        input logic [LEVEL_W-1:0]    h,
        input logic [LEVEL_W-1:0]    bo,
        input logic [LEVEL_W-1:0]    t,
        input logic [LEVEL_W-1:0]    r,
        input logic                  lit
    );
        lbg_req_t it;
        it.req_type = kind;
        it.bar      = b;
        it.height   = h;
        it.bottom   = bo;
        it.top      = t;
        it.row      = r;
        it.pixel_on = lit;
        return it;
    endfunction

    // Offer one request beat and hold it until the block takes it. An idle
    // burst drops valid first; otherwise valid stays high straight into the
    // next beat.
    task automatic push_request(input lbg_req_t it);
        if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 7 : 2) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= it.req_type;
        req_ch.bar      <= it.bar;
        req_ch.height   <= it.height;
        req_ch.bottom   <= it.bottom;
        req_ch.top      <= it.top;
        req_ch.row      <= it.row;
        req_ch.pixel_on <= it.pixel_on;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Readout sink: stall in bursts while idling is on, otherwise stay ready.
    initial
    begin
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 11 : 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        lbg_req_t it;
        int       beats;
        int       sel;

        idle_mode = 1;
        beats     = 0;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_BAR_HEIGHT;
        req_ch.bar      <= '0;
        req_ch.height   <= '0;
        req_ch.bottom   <= '0;
        req_ch.top      <= '0;
        req_ch.row      <= '0;
        req_ch.pixel_on <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: clamping edges, both halves of the top-row mapping,
        // ignored requests and every request code.
        push_request(mk(REQ_READOUT,    4'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_BAR_HEIGHT, 4'd0,  8'd20,  8'd0,   8'd0,   8'd0,   1'b0));
        // 127 is still a height, so it clamps to full
        push_request(mk(REQ_BAR_HEIGHT, 4'd9,  8'd127, 8'd0,   8'd0,   8'd0,   1'b0));
        // above 127 reads as empty
        push_request(mk(REQ_BAR_HEIGHT, 4'd5,  8'd128, 8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_BAR_HEIGHT, 4'd6,  8'd255, 8'hff,  8'hff,  8'hff,  1'b1));
        push_request(mk(REQ_BAR_HEIGHT, 4'd3,  8'd21,  8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_READOUT,    4'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_BAR_RANGE,  4'd1,  8'd0,   8'd0,   8'd255, 8'd0,   1'b0));
        // bottom above top collapses onto top
        push_request(mk(REQ_BAR_RANGE,  4'd7,  8'd0,   8'd200, 8'd5,   8'd0,   1'b0));
        push_request(mk(REQ_BAR_RANGE,  4'd4,  8'd0,   8'd255, 8'd255, 8'd0,   1'b0));
        push_request(mk(REQ_DOT,        4'd2,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_DOT,        4'd8,  8'd0,   8'd0,   8'd0,   8'd255, 1'b0));
        push_request(mk(REQ_PIXEL,      4'd6,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1));
        push_request(mk(REQ_PIXEL,      4'd5,  8'd0,   8'd0,   8'd0,   8'd19,  1'b1));
        // pixel line past the bottom row is dropped
        push_request(mk(REQ_PIXEL,      4'd5,  8'd0,   8'd0,   8'd0,   8'd20,  1'b1));
        push_request(mk(REQ_PIXEL,      4'd0,  8'd0,   8'd0,   8'd0,   8'd4,   1'b0));
        // bars past the last column are dropped
        push_request(mk(REQ_BAR_HEIGHT, 4'd15, 8'd20,  8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_DOT,        4'd10, 8'd0,   8'd0,   8'd0,   8'd3,   1'b0));
        push_request(mk(REQ_UNUSED,     4'd1,  8'd20,  8'd0,   8'd19,  8'd0,   1'b1));
        push_request(mk(REQ_READOUT,    4'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_CLEAR_BAR,  4'd9,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_CLEAR_BAR,  4'd2,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_READOUT,    4'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        push_request(mk(REQ_CLEAR_ALL,  4'd7,  8'd55,  8'd3,   8'd9,   8'd1,   1'b1));
        push_request(mk(REQ_READOUT,    4'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0));

        // Random part: mostly draws on real bars with sensible levels, regular
        // readouts, and a share of ignored requests as noise.
        while (beats < RANDOM_ITEMS)
        begin
            if (beats % 40 == 0)
                idle_mode = $urandom_range(0, 2);
            if (beats >= CALM_FROM)
                idle_mode = 0;

            it.req_type = REQ_TYPE_W'($urandom_range(0, 4));
            it.bar      = BAR_W'($urandom_range(0, LAST_BAR));
            it.height   = LEVEL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 22));
            it.bottom   = LEVEL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 21));
            it.top      = LEVEL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 21));
            it.row      = LEVEL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 19));
            it.pixel_on = 1'($urandom_range(0, 1));

            sel = $urandom_range(0, 99);
            if (sel < 14)
                it.req_type = REQ_READOUT;
            else if (sel < 17)
                it.req_type = REQ_CLEAR_ALL;
            else if (sel < 19)
                it.req_type = REQ_UNUSED;
            else if (sel < 22)
                it.bar = BAR_W'($urandom_range(LAST_BAR + 1, 15));
            else if (sel < 24)
            begin
                it.req_type = REQ_PIXEL;
                it.row      = LEVEL_W'($urandom_range(ROW_MAX + 1, 255));
            end

            push_request(it);
            beats++;
        end

        // Release the channel, let the checker log the last beat, then drain.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
